// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the serializer RTL.
// No dependencies; the NO_ASSERTIONS switch removes every check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Property checked at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition that must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

// ----- hw/rtl/mlcd_pkg.sv -----
// Types, constants and helper functions of the memory LCD frame serializer.
// No dependencies; the front, queue, back and top modules import this package.
package mlcd_pkg;

  // Display geometry.
  localparam int PIXELS_PER_LINE = 96;
  localparam int LINES           = 96;
  localparam int BYTES_PER_LINE  = PIXELS_PER_LINE / 8;

  // Byte capacity of one burst, and the slot index width.
  localparam int MAX_RESULTS = 5;
  localparam int SLOT_W      = $clog2(MAX_RESULTS + 1);

  // Queue between front and back.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  // Fixed bytes on the wire.
  localparam logic [7:0] BYTE_ZERO = 8'h00;
  localparam logic [7:0] LINE_ONE  = 8'h01;

  // Register reset values.
  localparam logic [7:0] WRITE_CMD_RST = 8'h80;
  localparam logic [7:0] VCOM_MASK_RST = 8'h40;
  localparam logic [7:0] CLEAR_CMD_RST = 8'h20;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_WRITE_CMD = 2'd0,
    CFG_VCOM_MASK = 2'd1,
    CFG_CLEAR_CMD = 2'd2
  } cfg_reg_e;

  // Request mode field.
  localparam logic MODE_DATA  = 1'b0;
  localparam logic MODE_CLEAR = 1'b1;

  // One burst of wire bytes produced by one accepted request.
  typedef struct packed {
    logic [SLOT_W-1:0]                count;
    logic                             ends;
    logic [MAX_RESULTS-1:0][7:0]      bytes;
  } burst_t;

  // Bit reversal: bit 0 of the input becomes bit 7 of the output.
  function automatic logic [7:0] rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int b = 0; b < 8; b++) begin
      r[7-b] = v[b];
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/mlcd_in_if.sv -----
// Request channel of the serializer: valid/ready plus the request fields.
// Depends on nothing.
interface mlcd_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] pixel_byte;

  modport source (output valid, output mode, output pixel_byte, input ready);
  modport sink   (input valid, input mode, input pixel_byte, output ready);
endinterface

// ----- hw/rtl/mlcd_out_if.sv -----
// Wire byte channel of the serializer: valid/ready plus byte and end flag.
// Depends on nothing.
interface mlcd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] wire_byte;
  logic       last;

  modport source (output valid, output wire_byte, output last, input ready);
  modport sink   (input valid, input wire_byte, input last, output ready);
endinterface

// ----- hw/rtl/mlcd_front.sv -----
// Front end: accepts requests, tracks frame position and VCOM, and builds
// one burst of wire bytes per request. Depends on mlcd_pkg and mlcd_in_if.
module mlcd_front
  import mlcd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  mlcd_in_if.sink            in_i,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [7:0]         cfg_data_i,
  input  logic               full_i,
  output logic               push_o,
  output burst_t             push_data_o
);

  logic [7:0] write_cmd_q, vcom_mask_q, clear_cmd_q;
  logic       vcom_q, vcom_d;
  logic [5:0] bil_q, bil_d;
  logic [7:0] line_q, line_d;
  burst_t     burst;

  // A request is taken whenever the queue has room.
  assign in_i.ready  = !full_i;
  assign push_o      = in_i.valid && !full_i;
  assign push_data_o = burst;

  // Build the burst and the next frame position.
  always_comb begin
    logic [SLOT_W-1:0] k;
    logic [7:0]        vc;
    logic [8:0]        next_line;
    k         = '0;
    vc        = vcom_q ? vcom_mask_q : BYTE_ZERO;
    next_line = {1'b0, line_q} + 9'd1;
    burst     = '0;
    vcom_d    = vcom_q;
    bil_d     = bil_q;
    line_d    = line_q;
    if (in_i.mode == MODE_CLEAR) begin
      burst.bytes[0] = clear_cmd_q | vc;
      burst.bytes[1] = BYTE_ZERO;
      k              = SLOT_W'(2);
      burst.ends     = 1'b1;
      vcom_d         = !vcom_q;
      bil_d          = '0;
      line_d         = '0;
    end else begin
      // Frame start: command byte and address of the first line.
      if (bil_q == '0 && line_q == '0) begin
        burst.bytes[0] = write_cmd_q | vc;
        burst.bytes[1] = rev8(LINE_ONE);
        k              = SLOT_W'(2);
        vcom_d         = !vcom_q;
      end
      burst.bytes[k] = rev8(in_i.pixel_byte);
      k              = k + SLOT_W'(1);
      // Line end: trailer, then next address or end of frame.
      if ({1'b0, bil_q} + 7'd1 >= 7'(BYTES_PER_LINE)) begin
        bil_d          = '0;
        burst.bytes[k] = BYTE_ZERO;
        k              = k + SLOT_W'(1);
        if (next_line < 9'(LINES)) begin
          line_d         = next_line[7:0];
          burst.bytes[k] = rev8(line_q + 8'd2);
        end else begin
          line_d         = '0;
          burst.bytes[k] = BYTE_ZERO;
          burst.ends     = 1'b1;
        end
        k = k + SLOT_W'(1);
      end else begin
        bil_d = bil_q + 6'd1;
      end
    end
    burst.count = k;
  end

  // Frame state and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcom_q      <= 1'b1;
      bil_q       <= '0;
      line_q      <= '0;
      write_cmd_q <= WRITE_CMD_RST;
      vcom_mask_q <= VCOM_MASK_RST;
      clear_cmd_q <= CLEAR_CMD_RST;
    end else begin
      if (push_o) begin
        vcom_q <= vcom_d;
        bil_q  <= bil_d;
        line_q <= line_d;
      end
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_idx_i))
          CFG_WRITE_CMD: write_cmd_q <= cfg_data_i;
          CFG_VCOM_MASK: vcom_mask_q <= cfg_data_i;
          CFG_CLEAR_CMD: clear_cmd_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

endmodule

// ----- hw/rtl/mlcd_fifo.sv -----
// Short burst queue between the front and back ends.
// Depends on mlcd_pkg and assert_macros.svh.
`include "assert_macros.svh"
module mlcd_fifo
  import mlcd_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  burst_t push_data_i,
  input  logic   pop_i,
  output burst_t head_o,
  output logic   full_o,
  output logic   empty_o
);

  burst_t             mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_q, rd_q;
  logic [FIFO_CW-1:0] cnt_q;

  assign full_o  = cnt_q == FIFO_CW'(FIFO_DEPTH);
  assign empty_o = cnt_q == '0;
  assign head_o  = mem_q[rd_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + FIFO_AW'(1);
      if (pop_i)  rd_q <= rd_q + FIFO_AW'(1);
      if (push_i && !pop_i)      cnt_q <= cnt_q + FIFO_CW'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - FIFO_CW'(1);
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  `ASSERT_NEVER(a_push_full, clk_i, rst_ni, push_i && full_o && !pop_i, "push into full queue")
  `ASSERT_NEVER(a_pop_empty, clk_i, rst_ni, pop_i && empty_o, "pop from empty queue")
  `ASSERT_CLK(a_cnt_range, clk_i, rst_ni, cnt_q <= FIFO_CW'(FIFO_DEPTH), "fill count overflow")

endmodule

// ----- hw/rtl/mlcd_back.sv -----
// Back end: walks the bytes of the head burst and drives the output register.
// Depends on mlcd_pkg, mlcd_out_if and assert_macros.svh.
`include "assert_macros.svh"
module mlcd_back
  import mlcd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  burst_t     head_i,
  input  logic       empty_i,
  output logic       pop_o,
  mlcd_out_if.source out_o
);

  logic [SLOT_W-1:0] slot_q;
  logic              ovalid_q;
  logic [7:0]        obyte_q;
  logic              olast_q;
  logic              load;
  logic              final_slot;

  assign out_o.valid     = ovalid_q;
  assign out_o.wire_byte = obyte_q;
  assign out_o.last      = olast_q;

  // Move one byte into the output register when it is free or being taken.
  assign load       = (!ovalid_q || out_o.ready) && !empty_i;
  assign final_slot = slot_q == head_i.count - SLOT_W'(1);
  assign pop_o      = load && final_slot;

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (load) begin
        ovalid_q <= 1'b1;
        slot_q   <= final_slot ? '0 : slot_q + SLOT_W'(1);
      end else if (out_o.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    if (load) begin
      obyte_q <= head_i.bytes[slot_q];
      olast_q <= head_i.ends && final_slot;
    end
  end

  `ASSERT_NEVER(a_slot_orphan, clk_i, rst_ni, slot_q != '0 && empty_i, "burst lost mid-walk")
  `ASSERT_CLK(a_slot_range, clk_i, rst_ni, empty_i || slot_q < head_i.count, "slot past burst")
  `ASSERT_NEVER(a_empty_burst, clk_i, rst_ni, !empty_i && head_i.count == '0, "empty burst queued")

endmodule

// ----- hw/rtl/memory_lcd_frame_serializer_core.sv -----
// Memory LCD frame serializer top level: front end, burst queue, back end.
// The first byte of a request passes through the burst queue, then the output register.
// Throughput: one wire byte per cycle unless the receiver stalls; a request
// gives 1 to 3 bytes, a new request each cycle while the 4-entry queue has room.
// Reset (rst_ni, async low): VCOM high, frame position 0, registers at default.
// Depends on mlcd_pkg, mlcd_in_if, mlcd_out_if, mlcd_front, mlcd_fifo, mlcd_back.
module memory_lcd_frame_serializer_core
  import mlcd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  mlcd_in_if.sink    in_i,
  mlcd_out_if.source out_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i
);

  logic   push, pop, full, empty;
  burst_t push_data, head;

  // Request decode and frame tracking.
  mlcd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .full_i      (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // Burst queue.
  mlcd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .full_o      (full),
    .empty_o     (empty)
  );

  // Byte output.
  mlcd_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .empty_i (empty),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps
// Testbench of memory_lcd_frame_serializer_core: directed and random requests.
// A predictor computes the wire bytes that each request must produce.
// Depends on mlcd_pkg, mlcd_in_if, mlcd_out_if and the serializer RTL.
module tb;
  import mlcd_pkg::*;

  // Register index that maps to no register; writes to it must be ignored.
  localparam logic [1:0] CFG_SPARE = 2'd3;
  // Cycles without any handshake before the run is declared hung.
  localparam int IDLE_LIMIT = 4000;
  // Length of the long receiver hold-off.
  localparam int HOLD_CYCLES = 300;

  // One wire byte as it leaves the block.
  typedef struct packed {
    logic [7:0] data;
    logic       ends;
  } wire_byte_t;

  // One request, with literal expected bytes when lit_count is not zero.
  typedef struct packed {
    logic            mode;
    logic [7:0]      pix;
    logic [2:0]      lit_count;
    logic [0:4][7:0] lit_bytes;
    logic [0:4]      lit_last;
  } step_t;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [7:0] cfg_data_i;

  mlcd_in_if  req_if ();
  mlcd_out_if byte_if ();

  memory_lcd_frame_serializer_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (req_if),
    .out_o      (byte_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Predictor copy of the registers and the frame position.
  logic [7:0] write_cmd;
  logic [7:0] vcom_mask;
  logic [7:0] clear_cmd;
  logic       vcom_high;
  logic [5:0] byte_pos;
  logic [7:0] line_pos;

  wire_byte_t wire_due[$];
  wire_byte_t burst[$];
  step_t      plan[$];

  int errors;
  int quiet_cycles;
  int send_idle_pct;
  int stall_pct;
  int hold_len;

  function automatic logic [7:0] mirror(input logic [7:0] v);
    return {<<{v}};
  endfunction

  function automatic logic [7:0] vcom_bits();
    return vcom_high ? vcom_mask : 8'h00;
  endfunction

  function automatic void emit(input logic [7:0] data, input logic ends);
    wire_byte_t b;
    b.data = data;
    b.ends = ends;
    burst.push_back(b);
  endfunction

  // Computes the wire bytes of one request into burst and advances the state.
  function automatic void serialize_request(input logic mode, input logic [7:0] pix);
    int next_line;
    burst.delete();
    if (mode == MODE_CLEAR) begin
      emit(clear_cmd | vcom_bits(), 1'b0);
      emit(BYTE_ZERO, 1'b1);
      vcom_high = ~vcom_high;
      byte_pos  = '0;
      line_pos  = '0;
      return;
    end
    // A data byte at the very start of a frame opens the transfer.
    if (byte_pos == 0 && line_pos == 0) begin
      emit(write_cmd | vcom_bits(), 1'b0);
      vcom_high = ~vcom_high;
      emit(mirror(LINE_ONE), 1'b0);
    end
    emit(mirror(pix), 1'b0);
    // At the line end comes the trailer, then the next address or the frame end.
    if (int'(byte_pos) + 1 >= BYTES_PER_LINE) begin
      next_line = int'(line_pos) + 1;
      byte_pos  = '0;
      emit(BYTE_ZERO, 1'b0);
      if (next_line < LINES) begin
        line_pos = 8'(next_line);
        emit(mirror(8'(next_line + 1)), 1'b0);
      end else begin
        line_pos = '0;
        emit(BYTE_ZERO, 1'b1);
      end
    end else begin
      byte_pos = byte_pos + 6'd1;
    end
  endfunction

  function automatic void set_register(input logic [1:0] idx, input logic [7:0] v);
    case (idx)
      CFG_WRITE_CMD: write_cmd = v;
      CFG_VCOM_MASK: vcom_mask = v;
      CFG_CLEAR_CMD: clear_cmd = v;
      default: ;
    endcase
  endfunction

  function automatic step_t row(input logic mode, input logic [7:0] pix,
                                input logic [2:0] count, input logic [0:4][7:0] bytes,
                                input logic [0:4] ends);
    step_t s;
    s.mode      = mode;
    s.pix       = pix;
    s.lit_count = count;
    s.lit_bytes = bytes;
    s.lit_last  = ends;
    return s;
  endfunction

  // Offers one request, possibly after an idle gap, and records its bytes.
  task automatic send(input step_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.mode       <= s.mode;
    req_if.pixel_byte <= s.pix;
    do @(posedge clk_i); while (!req_if.ready);
    serialize_request(s.mode, s.pix);
    if (s.lit_count == 0) begin
      foreach (burst[k]) wire_due.push_back(burst[k]);
    end else begin
      for (int k = 0; k < s.lit_count; k++) begin
        wire_due.push_back({s.lit_bytes[k], s.lit_last[k]});
      end
    end
    @(negedge clk_i);
  endtask

  // Drops valid and waits until every expected byte has left the block.
  task automatic settle();
    req_if.valid <= 1'b0;
    while (wire_due.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [7:0] v);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= v;
    set_register(idx, v);
    @(negedge clk_i);
  endtask

  // Writes all registers, and the unused index, while the block is idle.
  task automatic configure(input logic [7:0] w, input logic [7:0] m, input logic [7:0] c);
    settle();
    write_register(CFG_WRITE_CMD, w);
    write_register(CFG_SPARE, 8'($urandom_range(255)));
    write_register(CFG_VCOM_MASK, m);
    write_register(CFG_CLEAR_CMD, c);
    cfg_we_i <= 1'b0;
  endtask

  // Random requests, mostly data bytes with an occasional clear.
  task automatic run_phase(input int count, input int idle_pct, input int stall,
                           input int clear_pct);
    step_t s;
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    repeat (count) begin
      s = row(($urandom_range(99) < clear_pct) ? MODE_CLEAR : MODE_DATA,
              8'($urandom_range(255)), 3'd0, '0, '0);
      send(s);
    end
  endtask

  // Receiver: random stalls, and a long hold-off when one is requested.
  initial begin : receiver
    int n;
    byte_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_len != 0) begin
        n        = hold_len;
        hold_len = 0;
        byte_if.ready <= 1'b0;
        repeat (n) @(negedge clk_i);
      end else begin
        byte_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Compares each wire byte with the oldest expectation; watches for a hang.
  always @(posedge clk_i) begin : wire_check
    wire_byte_t want;
    if (rst_ni) begin
      if (byte_if.valid && byte_if.ready) begin
        if (wire_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected wire byte %h last %b", $time,
                   byte_if.wire_byte, byte_if.last);
        end else begin
          want = wire_due.pop_front();
          if (byte_if.wire_byte !== want.data) begin
            errors++;
            $display("%0t: wire byte expected %h, got %h", $time,
                     want.data, byte_if.wire_byte);
          end
          if (byte_if.last !== want.ends) begin
            errors++;
            $display("%0t: last expected %b, got %b", $time, want.ends, byte_if.last);
          end
        end
      end
      if ((byte_if.valid && byte_if.ready) || (req_if.valid && req_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = CFG_WRITE_CMD;
    cfg_data_i        = 8'h00;
    req_if.valid      = 1'b0;
    req_if.mode       = MODE_DATA;
    req_if.pixel_byte = 8'h00;
    send_idle_pct     = 0;
    stall_pct         = 0;
    hold_len          = 0;
    errors            = 0;
    quiet_cycles      = 0;
    write_cmd         = WRITE_CMD_RST;
    vcom_mask         = VCOM_MASK_RST;
    clear_cmd         = CLEAR_CMD_RST;
    vcom_high         = 1'b1;
    byte_pos          = '0;
    line_pos          = '0;

    // Directed requests from reset: frame start, extremes, clears mid-frame,
    // a full first line ending in the line 2 address, and a restart.
    plan.push_back(row(MODE_DATA, 8'h01, 3'd3, {8'hC0, 8'h80, 8'h80, 8'h00, 8'h00}, 5'b00000));
    plan.push_back(row(MODE_DATA, 8'h00, 3'd1, {8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 5'b00000));
    plan.push_back(row(MODE_DATA, 8'hFF, 3'd1, {8'hFF, 8'h00, 8'h00, 8'h00, 8'h00}, 5'b00000));
    plan.push_back(row(MODE_CLEAR, 8'h00, 3'd2, {8'h20, 8'h00, 8'h00, 8'h00, 8'h00}, 5'b01000));
    plan.push_back(row(MODE_CLEAR, 8'h5A, 3'd2, {8'h60, 8'h00, 8'h00, 8'h00, 8'h00}, 5'b01000));
    plan.push_back(row(MODE_DATA, 8'h80, 3'd3, {8'h80, 8'h80, 8'h01, 8'h00, 8'h00}, 5'b00000));
    plan.push_back(row(MODE_DATA, 8'h55, 3'd0, '0, '0));
    plan.push_back(row(MODE_DATA, 8'hAA, 3'd0, '0, '0));
    plan.push_back(row(MODE_DATA, 8'h0F, 3'd0, '0, '0));
    plan.push_back(row(MODE_DATA, 8'hF0, 3'd0, '0, '0));
    plan.push_back(row(MODE_DATA, 8'h01, 3'd0, '0, '0));
    plan.push_back(row(MODE_DATA, 8'h02, 3'd0, '0, '0));
    plan.push_back(row(MODE_DATA, 8'h04, 3'd0, '0, '0));
    plan.push_back(row(MODE_DATA, 8'h08, 3'd0, '0, '0));
    plan.push_back(row(MODE_DATA, 8'h10, 3'd0, '0, '0));
    plan.push_back(row(MODE_DATA, 8'h20, 3'd0, '0, '0));
    plan.push_back(row(MODE_DATA, 8'h40, 3'd3, {8'h02, 8'h00, 8'h40, 8'h00, 8'h00}, 5'b00000));
    plan.push_back(row(MODE_CLEAR, 8'hFF, 3'd0, '0, '0));
    plan.push_back(row(MODE_DATA, 8'h00, 3'd0, '0, '0));
    plan.push_back(row(MODE_DATA, 8'hC3, 3'd0, '0, '0));

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (plan[i]) send(plan[i]);

    // Data bytes without clears across several line ends, with all register
    // bits set and the clear command at zero.
    configure(8'hFF, 8'hFF, 8'h00);
    run_phase(90, 0, 0, 0);

    // Sender mostly idle, registers at zero except the clear command.
    configure(8'h00, 8'h00, 8'hFF);
    run_phase(80, 84, 0, 3);

    // Receiver mostly stalling, random registers.
    configure(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)));
    run_phase(80, 0, 84, 3);

    // Both sides idling now and then.
    configure(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)));
    run_phase(80, 26, 26, 4);

    // Long receiver hold-off while requests keep coming, so the block backs up;
    // then the sender waits for every byte before it goes on.
    configure(WRITE_CMD_RST, VCOM_MASK_RST, CLEAR_CMD_RST);
    hold_len = HOLD_CYCLES;
    run_phase(40, 0, 0, 5);
    settle();
    run_phase(40, 0, 10, 5);

    settle();
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
